>>> sv/wash_dry_cycle_sequencer_defines.svh
// assertion macros for the wash/dry cycle sequencer
// expects clk and rst_n in the scope of each use
`ifndef WASH_DRY_CYCLE_SEQUENCER_DEFINES_SVH
`define WASH_DRY_CYCLE_SEQUENCER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define WDCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define WDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/wdcs_pkg.sv
// shared types and constants for the wash/dry cycle sequencer
// no dependencies
`default_nettype none

package wdcs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RemW     = 18;

  localparam logic [3:0] NoticeSeconds = 4'd5;
  localparam logic signed [RemW-1:0] RemMin = {1'b1, {(RemW-1){1'b0}}};

  // request codes of an input item
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_DOOR  = 2'd3
  } req_t;

  // machine phases as reported in the phase field
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_READY  = 4'd1,
    PH_WET    = 4'd2,
    PH_DET    = 4'd3,
    PH_RINSE  = 4'd4,
    PH_GAP    = 4'd5,
    PH_BLOW   = 4'd6,
    PH_DONE   = 4'd7,
    PH_NOTICE = 4'd8
  } phase_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WASH_TOTAL = 3'd0,
    CFG_BLOW_TOTAL = 3'd1,
    CFG_FULL_WASH  = 3'd2,
    CFG_WET        = 3'd3,
    CFG_DET_RESV   = 3'd4,
    CFG_COOL_DOWN  = 3'd5,
    CFG_DISPENSE   = 3'd6,
    CFG_GAP        = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] wash_total_s;
    logic [15:0] blow_total_s;
    logic        full_wash;
    logic [7:0]  wet_s;
    logic [7:0]  detergent_reserve_s;
    logic [15:0] cool_down_s;
    logic [7:0]  dispense_s;
    logic [7:0]  gap_s;
  } cfg_t;

  typedef struct packed {
    logic wash_valve;
    logic detergent_pump;
    logic blower;
    logic heater;
    logic purple_lamp;
    logic main_lamp;
  } drive_t;

  typedef struct packed {
    drive_t      drv;
    logic [3:0]  phase;
    logic [15:0] wash_left;
    logic [15:0] blow_left;
  } result_t;

endpackage

`default_nettype wire

>>> sv/wdcs_if.sv
// valid/ready channel interfaces: input item, result item, config write
// depends on wdcs_pkg
`default_nettype none

interface wdcs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       door_closed;

  modport source (output valid, output req_type, output door_closed, input ready);
  modport sink   (input valid, input req_type, input door_closed, output ready);
endinterface

interface wdcs_out_if;
  logic        valid;
  logic        ready;
  logic        wash_valve;
  logic        detergent_pump;
  logic        blower;
  logic        heater;
  logic        purple_lamp;
  logic        main_lamp;
  logic [3:0]  phase;
  logic [15:0] wash_left;
  logic [15:0] blow_left;

  modport source (output valid, output wash_valve, output detergent_pump, output blower,
                  output heater, output purple_lamp, output main_lamp, output phase,
                  output wash_left, output blow_left, input ready);
  modport sink   (input valid, input wash_valve, input detergent_pump, input blower,
                  input heater, input purple_lamp, input main_lamp, input phase,
                  input wash_left, input blow_left, output ready);
endinterface

interface wdcs_cfg_if;
  import wdcs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/wdcs_core.sv
// cycle state machine: phase, countdowns, timers and drive levels
// depends on wdcs_pkg and wash_dry_cycle_sequencer_defines.svh
`default_nettype none
`include "wash_dry_cycle_sequencer_defines.svh"

module wdcs_core import wdcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [1:0] req_type,
  input  logic       door_closed,
  input  cfg_t       cfg,
  output result_t    res
);

  phase_t                 phase_r, phase_nxt;
  logic signed [RemW-1:0] wash_r, wash_nxt;
  logic signed [RemW-1:0] blow_r, blow_nxt;
  logic signed [RemW-1:0] blow_dec;
  logic [7:0]             ptimer_r, ptimer_nxt, ptimer_dec;
  logic [3:0]             ntimer_r, ntimer_nxt;
  drive_t                 drv_r, drv_nxt;
  logic                   expired;
  req_t                   req;

  // clamp a signed countdown into the 16-bit report range
  function automatic logic [15:0] clamp_left(input logic signed [RemW-1:0] v);
    logic [15:0] r;
    if (v <= 18'sd0) begin
      r = '0;
    end else if (v > $signed({{(RemW-16){1'b0}}, 16'hffff})) begin
      r = 16'hffff;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign req        = req_t'(req_type);
  assign expired    = (ptimer_r <= 8'd1);
  assign ptimer_dec = expired ? 8'd0 : ptimer_r - 8'd1;
  assign blow_dec   = (blow_r != RemMin) ? blow_r - 18'sd1 : blow_r;

  // next state for one item
  always_comb begin
    phase_nxt  = phase_r;
    wash_nxt   = wash_r;
    blow_nxt   = blow_r;
    ptimer_nxt = ptimer_r;
    ntimer_nxt = ntimer_r;
    drv_nxt    = drv_r;
    case (req)
      REQ_START: begin
        if (cfg.full_wash) begin
          wash_nxt = $signed({2'b00, cfg.wash_total_s});
        end else begin
          wash_nxt = $signed({2'b00, cfg.wash_total_s})
                   - $signed({10'd0, cfg.wet_s})
                   - $signed({10'd0, cfg.detergent_reserve_s});
        end
        blow_nxt          = $signed({2'b00, cfg.blow_total_s});
        phase_nxt         = PH_READY;
        ptimer_nxt        = '0;
        ntimer_nxt        = NoticeSeconds;
        drv_nxt           = '0;
        drv_nxt.main_lamp = 1'b1;
      end
      REQ_TICK: begin
        // wash time counts down through wetting, detergent and rinse
        if (phase_r inside {PH_WET, PH_DET, PH_RINSE} && wash_r != RemMin) begin
          wash_nxt = wash_r - 18'sd1;
        end
        case (phase_r)
          PH_READY: begin
            if (wash_r > 18'sd0) begin
              phase_nxt          = PH_WET;
              ptimer_nxt         = cfg.wet_s;
              drv_nxt.wash_valve = 1'b1;
            end else begin
              phase_nxt           = PH_BLOW;
              drv_nxt.blower      = 1'b1;
              drv_nxt.purple_lamp = 1'b1;
              drv_nxt.heater      = 1'b1;
            end
          end
          PH_WET: begin
            ptimer_nxt = ptimer_dec;
            if (expired) begin
              phase_nxt              = PH_DET;
              ptimer_nxt             = cfg.dispense_s;
              drv_nxt.detergent_pump = 1'b1;
            end
          end
          PH_DET: begin
            ptimer_nxt = ptimer_dec;
            if (expired) begin
              drv_nxt.detergent_pump = 1'b0;
              phase_nxt              = PH_RINSE;
            end
          end
          PH_RINSE: begin
            if (wash_nxt <= 18'sd0) begin
              drv_nxt.wash_valve = 1'b0;
              if (blow_r > 18'sd0) begin
                ptimer_nxt = cfg.gap_s;
                phase_nxt  = PH_GAP;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
          end
          PH_GAP: begin
            ptimer_nxt = ptimer_dec;
            if (expired) begin
              phase_nxt           = PH_BLOW;
              drv_nxt.blower      = 1'b1;
              drv_nxt.purple_lamp = 1'b1;
              drv_nxt.heater      = 1'b1;
            end
          end
          PH_BLOW: begin
            blow_nxt = blow_dec;
            // heater cut at the cool-down mark
            if (blow_dec == $signed({2'b00, cfg.cool_down_s})) begin
              drv_nxt.heater = 1'b0;
            end
            if (blow_dec <= 18'sd0) begin
              phase_nxt           = PH_DONE;
              drv_nxt.blower      = 1'b0;
              drv_nxt.purple_lamp = 1'b0;
              drv_nxt.heater      = 1'b0;
            end
          end
          PH_DONE: begin
            phase_nxt = PH_NOTICE;
          end
          PH_NOTICE: begin
            if (ntimer_r <= 4'd1) begin
              ntimer_nxt        = '0;
              drv_nxt.main_lamp = 1'b1;
              phase_nxt         = PH_IDLE;
            end else begin
              ntimer_nxt        = ntimer_r - 4'd1;
              drv_nxt.main_lamp = 1'b0;
            end
          end
          default: ;
        endcase
      end
      REQ_STOP: begin
        if (phase_r != PH_IDLE) begin
          drv_nxt   = '0;
          phase_nxt = PH_NOTICE;
        end
      end
      default: begin
        // door check: an open door stops a running cycle
        if (!door_closed && phase_r inside {[PH_READY:PH_DONE]}) begin
          drv_nxt   = '0;
          phase_nxt = PH_NOTICE;
        end
      end
    endcase
  end

  // result fields follow the state after this item
  always_comb begin
    res.drv       = drv_nxt;
    res.phase     = phase_nxt;
    res.wash_left = clamp_left(wash_nxt);
    res.blow_left = clamp_left(blow_nxt);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      wash_r   <= '0;
      blow_r   <= '0;
      ptimer_r <= '0;
      ntimer_r <= '0;
      drv_r    <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      wash_r   <= wash_nxt;
      blow_r   <= blow_nxt;
      ptimer_r <= ptimer_nxt;
      ntimer_r <= ntimer_nxt;
      drv_r    <= drv_nxt;
    end
  end

  // drive level consistency
  `WDCS_ASSERT_NOW(a_pump_in_det, drv_r.detergent_pump, phase_r == PH_DET, "pump on outside detergent phase")
  `WDCS_ASSERT_NOW(a_valve_in_wash, drv_r.wash_valve, phase_r == PH_WET || phase_r == PH_DET || phase_r == PH_RINSE, "valve open outside wash phases")
  `WDCS_ASSERT_NOW(a_heater_blower, drv_r.heater, drv_r.blower && drv_r.purple_lamp, "heater on without blower")
  `WDCS_ASSERT_NOW(a_idle_quiet, phase_r == PH_IDLE, !drv_r.wash_valve && !drv_r.detergent_pump && !drv_r.blower && !drv_r.heater, "drive active while idle")

endmodule

`default_nettype wire

>>> sv/wash_dry_cycle_sequencer.sv
// Wash/dry cycle sequencer, top level.
// Channels: in_item carries req_type (start, one-second tick, operator stop,
// door check) and door_closed; out_item returns one result item per input
// item with the six drive levels, the phase and the remaining wash and blow
// seconds; cfg_wr writes the eight configuration registers by index, always ready.
// Flow: an item taken into the input register has its result item computed
// by wdcs_core between the two registers and loaded into the result register
// once that register is free, so a stalled receiver holds it back.
// Throughput: one item per cycle while out_item.ready holds.
// A new item is taken while a finished result still waits in the output
// register; when the receiver stalls, the result register and then the
// input register fill, and in_item.ready drops until out_item.ready returns.
// Reset (synchronous, rst_n low) empties both registers, puts the machine in
// idle with all drives off and zero countdowns, and loads the register
// defaults: wet 30 s, detergent reserve 20 s, cool-down 180 s, dispense 5 s,
// gap 10 s, totals zero.
// depends on wdcs_pkg, wdcs_if, wdcs_core and wash_dry_cycle_sequencer_defines.svh
`default_nettype none
`include "wash_dry_cycle_sequencer_defines.svh"

module wash_dry_cycle_sequencer import wdcs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wdcs_in_if.sink     in_item,
  wdcs_out_if.source  out_item,
  wdcs_cfg_if.sink    cfg_wr
);

  logic       s1_valid_r;
  logic [1:0] s1_req_r;
  logic       s1_door_r;
  logic       out_valid_r;
  result_t    out_r;
  result_t    core_res;
  cfg_t       cfg_r;
  logic       adv2;
  logic       out_free;

  // handshake between the two registers
  assign out_free      = !out_valid_r || out_item.ready;
  assign adv2          = s1_valid_r && out_free;
  assign in_item.ready = !s1_valid_r || out_free;
  assign cfg_wr.ready  = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wash_total_s        <= 16'd0;
      cfg_r.blow_total_s        <= 16'd0;
      cfg_r.full_wash           <= 1'b0;
      cfg_r.wet_s               <= 8'd30;
      cfg_r.detergent_reserve_s <= 8'd20;
      cfg_r.cool_down_s         <= 16'd180;
      cfg_r.dispense_s          <= 8'd5;
      cfg_r.gap_s               <= 8'd10;
    end else if (cfg_wr.valid) begin
      case (cfg_idx_t'(cfg_wr.index))
        CFG_WASH_TOTAL: cfg_r.wash_total_s        <= cfg_wr.data;
        CFG_BLOW_TOTAL: cfg_r.blow_total_s        <= cfg_wr.data;
        CFG_FULL_WASH:  cfg_r.full_wash           <= cfg_wr.data[0];
        CFG_WET:        cfg_r.wet_s               <= cfg_wr.data[7:0];
        CFG_DET_RESV:   cfg_r.detergent_reserve_s <= cfg_wr.data[7:0];
        CFG_COOL_DOWN:  cfg_r.cool_down_s         <= cfg_wr.data;
        CFG_DISPENSE:   cfg_r.dispense_s          <= cfg_wr.data[7:0];
        CFG_GAP:        cfg_r.gap_s               <= cfg_wr.data[7:0];
        default: ;
      endcase
    end
  end

  // input register and result register valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_item.ready) begin
        s1_valid_r <= in_item.valid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      s1_req_r  <= in_item.req_type;
      s1_door_r <= in_item.door_closed;
    end
    if (adv2) begin
      out_r <= core_res;
    end
  end

  wdcs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (adv2),
    .req_type    (s1_req_r),
    .door_closed (s1_door_r),
    .cfg         (cfg_r),
    .res         (core_res)
  );

  // result channel
  assign out_item.valid          = out_valid_r;
  assign out_item.wash_valve     = out_r.drv.wash_valve;
  assign out_item.detergent_pump = out_r.drv.detergent_pump;
  assign out_item.blower         = out_r.drv.blower;
  assign out_item.heater         = out_r.drv.heater;
  assign out_item.purple_lamp    = out_r.drv.purple_lamp;
  assign out_item.main_lamp      = out_r.drv.main_lamp;
  assign out_item.phase          = out_r.phase;
  assign out_item.wash_left      = out_r.wash_left;
  assign out_item.blow_left      = out_r.blow_left;

  // pipeline bookkeeping
  `WDCS_ASSERT_NOW(a_stall_full, !in_item.ready, s1_valid_r && out_valid_r, "input stalled with a free stage")
  `WDCS_ASSERT_NOW(a_result_source, $rose(out_valid_r), $past(s1_valid_r), "result appeared without an item")

endmodule

`default_nettype wire
